[src/lphi_pkg.sv]
// Package for the linear-probing hash insert block.
// Holds field widths, action and status codes and the stored record type.
// No dependencies.
`default_nettype none

package lphi_pkg;

  // Fixed field widths of the stream payloads
  localparam int KEY_W   = 16;
  localparam int NAME_W  = 32;
  localparam int GRADE_W = 8;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 2;

  // Action codes (in_tuser)
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // Result status codes (out_tuser)
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_READ     = 2'd2;

  // One stored record, key in the low bits
  typedef struct packed {
    logic [GRADE_W-1:0] grade;
    logic [NAME_W-1:0]  name;
    logic [KEY_W-1:0]   key;
  } record_t;

  localparam int REC_W = KEY_W + NAME_W + GRADE_W;

endpackage

`default_nettype wire

[src/lphi_mod.sv]
// Remainder unit: key modulo TABLE_SIZE by reciprocal multiplication.
// Pipeline: load key, quotient from reciprocal product, remainder.
// Depends on lphi_pkg.
`default_nettype none

module lphi_mod #(
  parameter int TABLE_SIZE = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lphi_pkg::KEY_W-1:0]    dividend,
  output logic                               done,
  output logic [$clog2(TABLE_SIZE)-1:0]      rem
);

  localparam int KW    = lphi_pkg::KEY_W;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int SHIFT = KW + IDX_W;
  localparam int MW    = KW + 1;
  localparam int PW    = KW + MW;
  localparam int NW    = IDX_W + 1;
  localparam int BW    = KW + NW;
  // ceil(2^SHIFT / TABLE_SIZE): exact quotient for every KW-bit key
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
  localparam logic [NW-1:0] DIVISOR = NW'(TABLE_SIZE);

  logic              ld_r, ld_nxt;
  logic              quo_vld_r, quo_vld_nxt;
  logic              done_r, done_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [KW-1:0]     quo_r, quo_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [PW-1:0]     product;
  logic [BW-1:0]     back_mul;
  logic [BW-1:0]     diff;

  // Quotient estimate and remainder from the registered quotient
  assign product  = PW'(key_r) * PW'(RECIP_M);
  assign back_mul = BW'(quo_r) * BW'(DIVISOR);
  assign diff     = BW'(key_r) - back_mul;

  always_comb begin
    ld_nxt      = 1'b0;
    quo_vld_nxt = 1'b0;
    done_nxt    = 1'b0;
    key_nxt     = key_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    if (start) begin
      key_nxt = dividend;
      ld_nxt  = 1'b1;
    end
    if (ld_r) begin
      quo_nxt     = KW'(product >> SHIFT);
      quo_vld_nxt = 1'b1;
    end
    if (quo_vld_r) begin
      rem_nxt  = IDX_W'(diff);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r      <= 1'b0;
      quo_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      ld_r      <= ld_nxt;
      quo_vld_r <= quo_vld_nxt;
      done_r    <= done_nxt;
    end
    key_r <= key_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

[src/lphi_mem.sv]
// Record store: one write port, one read port with registered read data.
// Each entry keeps a record and the home slot it hashed to.
// Depends on lphi_pkg.
`default_nettype none

module lphi_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire lphi_pkg::record_t      wrec,
  input  wire logic [AW-1:0]          whome,
  input  wire logic [AW-1:0]          raddr,
  output lphi_pkg::record_t           rrec,
  output logic [AW-1:0]               rhome
);

  localparam int EW = lphi_pkg::REC_W + AW;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {whome, wrec};
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_r <= mem[raddr];
  end

  assign rrec  = lphi_pkg::record_t'(rd_r[lphi_pkg::REC_W-1:0]);
  assign rhome = rd_r[EW-1:lphi_pkg::REC_W];

endmodule

`default_nettype wire

[src/linear_probe_hash_insert.sv]
// Linear-probing hash table with insert and slot read over a stream port.
// Top level: sequencer, valid bits, fill count and output register.
// Depends on lphi_pkg, lphi_mod and lphi_mem.
//
// The block takes one beat at a time and holds in_tready low until that
// beat's result is in the output register. An insert hashes the key to its
// home slot (record_key mod TABLE_SIZE; a plain bit-select when the size is
// a power of two, otherwise a reciprocal-multiply remainder unit), then
// probes one slot per cycle from home, wrapping, to the first free slot.
// An insert passes through S_MOD when the size is not a power of two, then
// S_HOME, S_HCHK when replace mode checks the home entry, S_PROBE and
// S_DONE; a read passes through S_RDDATA and S_DONE, a full-table insert
// goes straight to S_DONE. The result waits in S_DONE while the output
// register is full and its beat is not yet taken.
// With replace_mode set, a home slot held by a record from another home is
// given to the new record and the old one is re-probed onward; since a full
// table is refused first, the re-probe always finds room. Valid bits clear
// at reset, so the table is usable on the first cycle after reset.
`default_nettype none

module linear_probe_hash_insert #(
  parameter int TABLE_SIZE = 16,
  parameter int KEY_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: replace_mode
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  // input beats
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // record_key, name_word, grade_code, read_slot
  input  wire logic [0:0]  in_tuser,  // action
  // result beats
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata, // placed_slot, moved_flag, moved_slot, slot_valid,
                                      // slot_key, slot_name, slot_grade
  output logic [1:0]       out_tuser  // status
);

  localparam int KW      = lphi_pkg::KEY_W;
  localparam int SW      = lphi_pkg::SLOT_W;
  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int UW      = $clog2(TABLE_SIZE + 1);
  localparam int KEY_EFF = (KEY_BITS < KW) ? KEY_BITS : KW;
  localparam logic [KW-1:0] KEY_MASK = KW'((32'd1 << KEY_EFF) - 32'd1);
  localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOD    = 3'd1;
  localparam logic [2:0] S_HOME   = 3'd2;
  localparam logic [2:0] S_HCHK   = 3'd3;
  localparam logic [2:0] S_PROBE  = 3'd4;
  localparam logic [2:0] S_RDDATA = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // Input fields
  logic                 in_action;
  logic [KW-1:0]        in_key;
  lphi_pkg::record_t    in_rec;
  logic [SW-1:0]        in_slot;
  logic                 in_acc;

  assign in_action   = in_tuser[0];
  assign in_key      = in_tdata[15:0] & KEY_MASK;
  assign in_rec.key  = in_key;
  assign in_rec.name = in_tdata[47:16];
  assign in_rec.grade = in_tdata[55:48];
  assign in_slot     = in_tdata[59:56];
  assign in_acc      = in_tvalid && in_tready;

  // Control state
  logic [2:0]             state_r, state_nxt;
  logic [TABLE_SIZE-1:0]  valid_r, valid_nxt;
  logic [UW-1:0]          used_r, used_nxt;
  logic                   replace_r;
  logic                   out_valid_r, out_valid_nxt;

  // Working registers
  logic [IDX_W-1:0]       home_r, home_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  lphi_pkg::record_t      pend_rec_r, pend_rec_nxt;
  logic [IDX_W-1:0]       pend_home_r, pend_home_nxt;

  // Pending result
  logic [1:0]             res_status_r, res_status_nxt;
  logic [SW-1:0]          res_placed_r, res_placed_nxt;
  logic                   res_moved_r, res_moved_nxt;
  logic [SW-1:0]          res_mslot_r, res_mslot_nxt;
  logic                   res_valid_r, res_valid_nxt;
  lphi_pkg::record_t      res_rec_r, res_rec_nxt;

  // Output register
  logic [71:0]            out_tdata_r, out_tdata_nxt;
  logic [1:0]             out_tuser_r, out_tuser_nxt;

  // Remainder unit and store connections
  logic                   mod_start;
  logic                   mod_done;
  logic [IDX_W-1:0]       mod_rem;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [IDX_W-1:0]       mem_raddr;
  lphi_pkg::record_t      mem_rrec;
  logic [IDX_W-1:0]       mem_rhome;

  logic                   rd_in_range;
  logic                   probe_free;
  logic                   misplaced;
  logic                   out_free;

  assign in_tready   = (state_r == S_IDLE);
  assign rd_in_range = (9'(in_slot) < 9'(TABLE_SIZE));
  assign probe_free  = !valid_r[idx_r];
  assign misplaced   = (mem_rhome != home_r);
  assign out_free    = !out_valid_r || out_tready;

  assign mod_start = in_acc && (in_action == lphi_pkg::ACT_INSERT) &&
                     (used_r != UW'(TABLE_SIZE)) && !IS_POW2;

  lphi_mod #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_key),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Store port selection
  assign mem_we    = ((state_r == S_HCHK) && misplaced) ||
                     ((state_r == S_PROBE) && probe_free);
  assign mem_waddr = (state_r == S_HCHK) ? home_r : idx_r;
  assign mem_raddr = (state_r == S_IDLE) ? IDX_W'(in_slot) : home_r;

  lphi_mem #(
    .DEPTH (TABLE_SIZE),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wrec  (pend_rec_r),
    .whome (pend_home_r),
    .raddr (mem_raddr),
    .rrec  (mem_rrec),
    .rhome (mem_rhome)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r;
    home_nxt       = home_r;
    idx_nxt        = idx_r;
    pend_rec_nxt   = pend_rec_r;
    pend_home_nxt  = pend_home_r;
    res_status_nxt = res_status_r;
    res_placed_nxt = res_placed_r;
    res_moved_nxt  = res_moved_r;
    res_mslot_nxt  = res_mslot_r;
    res_valid_nxt  = res_valid_r;
    res_rec_nxt    = res_rec_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    // output beat taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_placed_nxt = '0;
          res_moved_nxt  = 1'b0;
          res_mslot_nxt  = '0;
          res_valid_nxt  = 1'b0;
          res_rec_nxt    = '0;
          pend_rec_nxt   = in_rec;
          if (in_action == lphi_pkg::ACT_READ) begin
            res_status_nxt = lphi_pkg::ST_READ;
            res_valid_nxt  = rd_in_range && valid_r[IDX_W'(in_slot)];
            state_nxt      = S_RDDATA;
          end else if (used_r == UW'(TABLE_SIZE)) begin
            res_status_nxt = lphi_pkg::ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            res_status_nxt = lphi_pkg::ST_INSERTED;
            if (IS_POW2) begin
              home_nxt  = IDX_W'(in_key);
              state_nxt = S_HOME;
            end else begin
              state_nxt = S_MOD;
            end
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          home_nxt  = mod_rem;
          state_nxt = S_HOME;
        end
      end
      S_HOME: begin
        pend_home_nxt = home_r;
        idx_nxt       = home_r;
        if (replace_r && valid_r[home_r]) begin
          state_nxt = S_HCHK;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_HCHK: begin
        // home entry belongs elsewhere: new record takes it, old one re-probes
        if (misplaced) begin
          pend_rec_nxt   = mem_rrec;
          pend_home_nxt  = mem_rhome;
          res_moved_nxt  = 1'b1;
          res_placed_nxt = SW'(home_r);
        end
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (probe_free) begin
          valid_nxt[idx_r] = 1'b1;
          used_nxt         = used_r + UW'(1);
          if (res_moved_r) begin
            res_mslot_nxt = SW'(idx_r);
          end else begin
            res_placed_nxt = SW'(idx_r);
          end
          state_nxt = S_DONE;
        end else if (idx_r == IDX_W'(TABLE_SIZE - 1)) begin
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_RDDATA: begin
        res_rec_nxt = res_valid_r ? mem_rrec : '0;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tuser_nxt = res_status_r;
          out_tdata_nxt = {6'b0, res_rec_r.grade, res_rec_r.name, res_rec_r.key,
                           res_valid_r, res_mslot_r, res_moved_r, res_placed_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      used_r      <= '0;
      replace_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        replace_r <= cfg_wr_data;
      end
    end
    home_r       <= home_nxt;
    idx_r        <= idx_nxt;
    pend_rec_r   <= pend_rec_nxt;
    pend_home_r  <= pend_home_nxt;
    res_status_r <= res_status_nxt;
    res_placed_r <= res_placed_nxt;
    res_moved_r  <= res_moved_nxt;
    res_mslot_r  <= res_mslot_nxt;
    res_valid_r  <= res_valid_nxt;
    res_rec_r    <= res_rec_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire
